FILE: hw/rtl/mme_pkg.sv
// Shared constants, field widths and helper functions of the matrix multiply engine.
// No dependencies; used by scoped names in mme_ram users and the top level.
`default_nettype none

package mme_pkg;

	localparam int MAX_DIM   = 8;
	localparam int ELEM_BITS = 16;
	localparam int DIM_BITS  = 3;
	localparam int CFG_BITS  = 4;
	localparam int OP_BITS   = 2;
	localparam int SUM_BITS  = 35;
	localparam int PROD_BITS = 2 * ELEM_BITS;
	localparam int ADDR_BITS = 2 * DIM_BITS;
	localparam int DEPTH     = MAX_DIM * MAX_DIM;

	localparam int IN_FIELD_BITS  = 2 * DIM_BITS + ELEM_BITS;
	localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
	localparam int OUT_FIELD_BITS = 2 * DIM_BITS + SUM_BITS;
	localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

	localparam int PADDR_BITS = 4;
	localparam int PDATA_BITS = 32;

	localparam logic [OP_BITS-1:0] OP_LOAD_A = 2'd0;
	localparam logic [OP_BITS-1:0] OP_LOAD_B = 2'd1;
	localparam logic [OP_BITS-1:0] OP_START  = 2'd2;

	localparam logic [1:0] REG_ROWS_A = 2'd0;
	localparam logic [1:0] REG_A_COLS = 2'd1;
	localparam logic [1:0] REG_B_ROWS = 2'd2;
	localparam logic [1:0] REG_B_COLS = 2'd3;

	typedef logic [CFG_BITS-1:0] dim_t;

	// Dimensions above MAX_DIM count as MAX_DIM.
	function automatic dim_t clamp_dim(input dim_t d);
		return (d > CFG_BITS'(MAX_DIM)) ? CFG_BITS'(MAX_DIM) : d;
	endfunction

	// Highest index of a clamped dimension; zero for a zero dimension.
	function automatic logic [DIM_BITS-1:0] dim_last(input dim_t d);
		dim_t c;
		dim_t m;
		c = clamp_dim(d);
		m = c - CFG_BITS'(1);
		return (c == '0) ? '0 : m[DIM_BITS-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/mme_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mme_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: hw/rtl/matrix_multiply_engine_top.sv
// Matrix multiply engine: A and B elements are written to the element stores by loads.
// A start runs one shared 16x16 multiplier and a 35-bit accumulator over the
// inner dimension. For each C element it waits for the output register, issues the
// inner-product terms in turn, then registers RAM read data (s1) and product (s2).
// A matching start with zero A rows or zero B columns produces no beat.
// A dimension mismatch gives one error beat, sent once the output register is free.
// Reset (arst_n low, asynchronous) sets all dimensions to 1; element stores are not cleared.
// Depends on mme_pkg and mme_ram.
`default_nettype none

module matrix_multiply_engine_top (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// s_tdata: row[2:0], col[5:3], value[21:6], zero pad above
	input  wire logic [mme_pkg::IN_DATA_BITS-1:0]    s_tdata,
	// s_tuser: opcode[1:0]
	input  wire logic [mme_pkg::OP_BITS-1:0]         s_tuser,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// m_tdata: out_row[2:0], out_col[5:3], sum[40:6], zero pad above
	output logic      [mme_pkg::OUT_DATA_BITS-1:0]   m_tdata,
	// m_tuser: dim_error[0]
	output logic      [0:0]                          m_tuser,
	output logic                                     m_tlast,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [mme_pkg::PADDR_BITS-1:0]      paddr,
	input  wire logic [mme_pkg::PDATA_BITS-1:0]      pwdata,
	output logic      [mme_pkg::PDATA_BITS-1:0]      prdata,
	output logic                                     pready
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_NEXT  = 3'd1;
	localparam logic [2:0] ST_ISSUE = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_ERR   = 3'd4;

	localparam int DB = mme_pkg::DIM_BITS;
	localparam int EB = mme_pkg::ELEM_BITS;
	localparam int SB = mme_pkg::SUM_BITS;
	localparam int CB = mme_pkg::CFG_BITS;

	// Configuration registers
	mme_pkg::dim_t rows_a_q, a_cols_q, b_rows_q, b_cols_q;
	logic          cfg_wr;
	logic [1:0]    cfg_idx;

	// Sequencer
	logic [2:0]    state_q;
	logic [DB-1:0] i_q, j_q, t_q;
	logic [DB-1:0] nr_last_q, nc_last_q, nk_last_q;
	logic          nk_zero_q;

	// Input fields
	logic                       in_acc;
	logic [mme_pkg::OP_BITS-1:0] in_op;
	logic [DB-1:0]              in_row, in_col;
	logic [EB-1:0]              in_value;

	// Datapath pipeline
	logic                     vld_s1, last_s1, first_s1, zero_s1;
	logic                     vld_s2, last_s2, first_s2;
	logic signed [mme_pkg::PROD_BITS-1:0] mul_prod;
	logic signed [mme_pkg::PROD_BITS-1:0] prod_s2;
	logic signed [SB-1:0]     acc_q;
	logic signed [SB-1:0]     acc_next;
	logic [EB-1:0]            a_rdata, b_rdata;
	logic                     issue;

	// Output register
	logic          out_vld_q;
	logic [DB-1:0] out_row_q, out_col_q;
	logic [SB-1:0] out_sum_q;
	logic          out_err_q, out_last_q;
	logic          out_free;
	logic          res_done, err_load;
	logic          elem_last;

	assign in_row   = s_tdata[DB-1:0];
	assign in_col   = s_tdata[2*DB-1:DB];
	assign in_value = s_tdata[2*DB+EB-1:2*DB];
	assign in_op    = s_tuser;

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;

	// APB configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q <= CB'(1);
			a_cols_q <= CB'(1);
			b_rows_q <= CB'(1);
			b_cols_q <= CB'(1);
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				mme_pkg::REG_ROWS_A: rows_a_q <= pwdata[CB-1:0];
				mme_pkg::REG_A_COLS: a_cols_q <= pwdata[CB-1:0];
				mme_pkg::REG_B_ROWS: b_rows_q <= pwdata[CB-1:0];
				mme_pkg::REG_B_COLS: b_cols_q <= pwdata[CB-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (cfg_idx)
			mme_pkg::REG_ROWS_A: prdata[CB-1:0] = rows_a_q;
			mme_pkg::REG_A_COLS: prdata[CB-1:0] = a_cols_q;
			mme_pkg::REG_B_ROWS: prdata[CB-1:0] = b_rows_q;
			mme_pkg::REG_B_COLS: prdata[CB-1:0] = b_cols_q;
			default: prdata = '0;
		endcase
	end

	// Element stores
	mme_ram #(.WIDTH(EB), .DEPTH(mme_pkg::DEPTH)) u_a_ram (
		.clk  (clk),
		.we   (in_acc && (in_op == mme_pkg::OP_LOAD_A)),
		.waddr({in_row, in_col}),
		.wdata(in_value),
		.raddr({j_q, t_q}),
		.rdata(a_rdata)
	);

	mme_ram #(.WIDTH(EB), .DEPTH(mme_pkg::DEPTH)) u_b_ram (
		.clk  (clk),
		.we   (in_acc && (in_op == mme_pkg::OP_LOAD_B)),
		.waddr({in_row, in_col}),
		.wdata(in_value),
		.raddr({t_q, i_q}),
		.rdata(b_rdata)
	);

	assign out_free  = !out_vld_q || m_tready;
	assign issue     = (state_q == ST_ISSUE);
	assign res_done  = vld_s2 && last_s2;
	assign err_load  = (state_q == ST_ERR) && out_free;
	assign elem_last = (i_q == nc_last_q) && (j_q == nr_last_q);

	// Sequencer: one C element at a time, one inner-product term per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			i_q       <= '0;
			j_q       <= '0;
			t_q       <= '0;
			nr_last_q <= '0;
			nc_last_q <= '0;
			nk_last_q <= '0;
			nk_zero_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && (in_op == mme_pkg::OP_START)) begin
						i_q       <= '0;
						j_q       <= '0;
						t_q       <= '0;
						nr_last_q <= mme_pkg::dim_last(rows_a_q);
						nc_last_q <= mme_pkg::dim_last(b_cols_q);
						nk_last_q <= mme_pkg::dim_last(a_cols_q);
						nk_zero_q <= (a_cols_q == '0);
						if (a_cols_q != b_rows_q) begin
							state_q <= ST_ERR;
						end else if ((rows_a_q == '0) || (b_cols_q == '0)) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_NEXT;
						end
					end
				end
				ST_NEXT: begin
					// hold until the output register can take this element's beat
					if (out_free) begin
						t_q     <= '0;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					if (t_q == nk_last_q) begin
						state_q <= ST_DRAIN;
					end else begin
						t_q <= t_q + DB'(1);
					end
				end
				ST_DRAIN: begin
					if (res_done) begin
						if (elem_last) begin
							state_q <= ST_IDLE;
						end else begin
							if (j_q == nr_last_q) begin
								j_q <= '0;
								i_q <= i_q + DB'(1);
							end else begin
								j_q <= j_q + DB'(1);
							end
							state_q <= ST_NEXT;
						end
					end
				end
				ST_ERR: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
		end
	end

	assign mul_prod = $signed(a_rdata) * $signed(b_rdata);

	// Pipeline payload: read data arrives with s1, product registered in s2
	always_ff @(posedge clk) begin
		last_s1  <= (t_q == nk_last_q);
		first_s1 <= (t_q == '0);
		zero_s1  <= nk_zero_q;
		last_s2  <= last_s1;
		first_s2 <= first_s1;
		// drop the term when the inner dimension is zero
		prod_s2  <= zero_s1 ? '0 : mul_prod;
	end

	assign acc_next = (first_s2 ? SB'(0) : acc_q) + SB'(prod_s2);

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			acc_q <= acc_next;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_done || err_load) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_done) begin
			out_row_q  <= j_q;
			out_col_q  <= i_q;
			out_sum_q  <= acc_next;
			out_err_q  <= 1'b0;
			out_last_q <= elem_last;
		end else if (err_load) begin
			out_row_q  <= '0;
			out_col_q  <= '0;
			out_sum_q  <= '0;
			out_err_q  <= 1'b1;
			out_last_q <= 1'b1;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = mme_pkg::OUT_DATA_BITS'({out_sum_q, out_col_q, out_row_q});
	assign m_tuser  = out_err_q;
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire
